// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decoder RTL
// Clocked, reset-qualified property checks reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset
`define DRLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset
`define DRLD_NEVER(lbl, cond, msg) \
	`DRLD_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/drld_pkg.sv =====
// ----------------------------------------------------------------------------
// drld_pkg
// Shared types and codes of the depth-map run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package drld_pkg;

	// Default largest accepted frame side
	localparam int MAX_SIDE_DEF = 2048;

	// Result field widths
	localparam int KIND_W = 2;
	localparam int RUN_W  = 23;
	localparam int SMP_W  = 16;
	localparam int IDX_W  = 22;
	localparam int ERR_W  = 2;

	// Result queue depth
	localparam int QUEUE_DEPTH = 4;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_TRUNC    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_SIZE     = 2'd3;

	// One decoded result
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [RUN_W-1:0]  run;
		logic [SMP_W-1:0]  smp;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic [ERR_W-1:0]  err;
	} rec_t;

	// Queue status seen by the output stage and the input handshake
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== sv/drld_front.sv =====
// ----------------------------------------------------------------------------
// drld_front
// Byte parser: assembles header and run fields, tracks the pixel position
// and produces at most one result record per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module drld_front #(
	parameter int MAX_SIDE = drld_pkg::MAX_SIDE_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_end,
	output drld_pkg::rec_t     rec,
	output logic               push
);

	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int TOTAL_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int RUN_W   = drld_pkg::RUN_W;
	localparam int IDX_W   = drld_pkg::IDX_W;

	// Parser phases
	localparam logic [2:0] PH_WIDTH  = 3'd0;
	localparam logic [2:0] PH_HEIGHT = 3'd1;
	localparam logic [2:0] PH_EMPTY  = 3'd2;
	localparam logic [2:0] PH_FULL   = 3'd3;
	localparam logic [2:0] PH_SAMPLE = 3'd4;

	logic [2:0]           phase_q, phase_d;
	logic [1:0]           cnt_q, cnt_d;
	logic [23:0]          field_q, field_d;
	logic [SIDE_W-1:0]    width_q, width_d;
	logic [TOTAL_W-1:0]   total_q, total_d;
	logic [TOTAL_W-1:0]   pos_q, pos_d;
	logic [TOTAL_W-1:0]   left_q, left_d;
	logic                 discard_q, discard_d;

	logic                 done;
	logic [31:0]          v32;
	logic [15:0]          v16;
	logic [TOTAL_W-1:0]   v_tot;
	logic [TOTAL_W-1:0]   rem;
	logic                 too_big;
	logic                 over;
	logic [2*SIDE_W-1:0]  prod;
	logic [drld_pkg::ERR_W-1:0] err;
	logic                 emit;

	// Field value as it completes with this byte
	assign v32     = {in_byte, field_q};
	assign v16     = {in_byte, field_q[7:0]};
	assign v_tot   = v32[TOTAL_W-1:0];
	assign rem     = total_q - pos_q;
	assign done    = (phase_q == PH_SAMPLE) ? (cnt_q == 2'd1) : (cnt_q == 2'd3);
	assign too_big = v32 > 32'(MAX_SIDE);
	assign over    = v32 > 32'(rem);
	assign prod    = width_q * v32[SIDE_W-1:0];

	// Decide next state and the result of this byte
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q + 2'd1;
		field_d   = field_q;
		width_d   = width_q;
		total_d   = total_q;
		pos_d     = pos_q;
		left_d    = left_q;
		discard_d = discard_q;
		err       = drld_pkg::ERR_NONE;
		emit      = 1'b0;
		rec       = '0;
		if (!discard_q) begin
			if (!done) begin
				case (cnt_q)
					2'd0: field_d[7:0] = in_byte;
					2'd1: field_d[15:8] = in_byte;
					default: field_d[23:16] = in_byte;
				endcase
			end else begin
				cnt_d   = 2'd0;
				field_d = '0;
				case (phase_q)
					PH_WIDTH: begin
						if (too_big) begin
							err = drld_pkg::ERR_SIZE;
						end else begin
							width_d = v32[SIDE_W-1:0];
							phase_d = PH_HEIGHT;
						end
					end
					PH_HEIGHT: begin
						if (too_big) begin
							err = drld_pkg::ERR_SIZE;
						end else begin
							total_d = prod[TOTAL_W-1:0];
							pos_d   = '0;
							if (width_q == '0 || v32 == '0) begin
								// Empty frame: one zero-length run closes it
								rec.kind  = drld_pkg::KIND_RUN;
								rec.last  = 1'b1;
								emit      = 1'b1;
								discard_d = 1'b1;
							end else begin
								phase_d = PH_EMPTY;
							end
						end
					end
					PH_EMPTY: begin
						if (over) begin
							err = drld_pkg::ERR_OVERFLOW;
						end else begin
							rec.kind = drld_pkg::KIND_RUN;
							rec.run  = RUN_W'(v_tot);
							rec.idx  = IDX_W'(pos_q);
							rec.last = (v_tot == rem);
							emit     = 1'b1;
							pos_d    = pos_q + v_tot;
							if (v_tot == rem) begin
								discard_d = 1'b1;
							end else begin
								phase_d = PH_FULL;
							end
						end
					end
					PH_FULL: begin
						if (over) begin
							err = drld_pkg::ERR_OVERFLOW;
						end else if (v32 == '0) begin
							phase_d = PH_EMPTY;
						end else begin
							left_d  = v_tot;
							phase_d = PH_SAMPLE;
						end
					end
					default: begin
						rec.kind = drld_pkg::KIND_SAMPLE;
						rec.smp  = v16;
						rec.idx  = IDX_W'(pos_q);
						rec.last = (rem == TOTAL_W'(1));
						emit     = 1'b1;
						pos_d    = pos_q + TOTAL_W'(1);
						left_d   = left_q - TOTAL_W'(1);
						if (rem == TOTAL_W'(1)) begin
							discard_d = 1'b1;
						end else if (left_q == TOTAL_W'(1)) begin
							phase_d = PH_EMPTY;
						end
					end
				endcase
			end
			// Flag errors, then a stream end inside an unfinished frame
			if (err != drld_pkg::ERR_NONE) begin
				rec       = '0;
				rec.kind  = drld_pkg::KIND_STATUS;
				rec.idx   = IDX_W'(pos_q);
				rec.err   = err;
				emit      = 1'b1;
				discard_d = 1'b1;
			end else if (in_end && !discard_d) begin
				if (!emit) begin
					rec.kind = drld_pkg::KIND_STATUS;
					rec.idx  = IDX_W'(pos_q);
				end
				rec.err = drld_pkg::ERR_TRUNC;
				emit    = 1'b1;
			end
		end
		// Start a fresh frame after the stream end
		if (in_end) begin
			phase_d   = PH_WIDTH;
			cnt_d     = 2'd0;
			field_d   = '0;
			width_d   = '0;
			total_d   = '0;
			pos_d     = '0;
			left_d    = '0;
			discard_d = 1'b0;
		end
	end

	assign push = take & emit;

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WIDTH;
			cnt_q     <= 2'd0;
			field_q   <= '0;
			width_q   <= '0;
			total_q   <= '0;
			pos_q     <= '0;
			left_q    <= '0;
			discard_q <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			field_q   <= field_d;
			width_q   <= width_d;
			total_q   <= total_d;
			pos_q     <= pos_d;
			left_q    <= left_d;
			discard_q <= discard_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/drld_fifo.sv =====
// ----------------------------------------------------------------------------
// drld_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module drld_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire drld_pkg::rec_t wr_rec,
	input  wire logic           pop,
	output drld_pkg::rec_t      rd_rec,
	output drld_pkg::q_stat_t   stat
);

	localparam int DEPTH = drld_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	drld_pkg::rec_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push & ~stat.full;
	assign do_pop     = pop & ~stat.empty;
	assign rd_rec     = mem_q[rd_ptr_q];

	// Store pushed records
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/drld_back.sv =====
// ----------------------------------------------------------------------------
// drld_back
// Output stage: pulls records from the queue into a register and packs them
// onto the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module drld_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire drld_pkg::q_stat_t stat,
	input  wire drld_pkg::rec_t    rd_rec,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	logic           valid_q;
	drld_pkg::rec_t rec_q;

	// Load when the register is empty or being drained
	assign pop = ~stat.empty & (~valid_q | m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= rd_rec;
		end
	end

	// Pack fields, lowest first
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, rec_q.err, rec_q.idx, rec_q.smp, rec_q.run};
	assign m_tuser  = rec_q.kind;
	assign m_tlast  = rec_q.last;

endmodule

`default_nettype wire

// ===== sv/depth_run_length_decoder_core.sv =====
// ----------------------------------------------------------------------------
// depth_run_length_decoder_core
// Decoder of run-length compressed depth-map byte streams.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle and, as long as the output
// side keeps draining, never stalls: each byte only shifts a field register
// and updates the pixel counters, so the sustained rate is one byte per
// cycle. A byte yields at most one result; results pass through a
// four-entry queue and an output register, and the input side keeps
// running until the queue fills. Frame sides above MAX_SIDE are rejected
// with a bad-size status, and a run past the frame with an overflow
// status; the rest of that stream is then dropped until the byte marked
// tlast. A stream end before the frame completes is flagged with a
// truncation error.
`default_nettype none

`include "assert_macros.svh"

module depth_run_length_decoder_core #(
	parameter int MAX_SIDE = drld_pkg::MAX_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [22:0] zero_run_length, [38:23] sample,
	                                    // [60:39] pixel_index, [62:61] error, [63] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last_pixel
);

	drld_pkg::rec_t    push_rec;
	drld_pkg::rec_t    rd_rec;
	drld_pkg::q_stat_t stat;
	logic              take;
	logic              push;
	logic              pop;

	// Accept bytes while the queue has room
	assign s_tready = ~stat.full;
	assign take     = s_tvalid & s_tready;

	drld_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.in_byte(s_tdata),
		.in_end (s_tlast),
		.rec    (push_rec),
		.push   (push)
	);

	drld_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_rec(push_rec),
		.pop   (pop),
		.rd_rec(rd_rec),
		.stat  (stat)
	);

	drld_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (stat),
		.rd_rec  (rd_rec),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// Checks
	`DRLD_NEVER(a_push_full, push && stat.full, "result pushed into a full queue")
	`DRLD_ASSERT(a_status_err, (m_tvalid && m_tuser == drld_pkg::KIND_STATUS) |-> (m_tdata[62:61] != drld_pkg::ERR_NONE && !m_tlast), "status result without error or marked last")
	`DRLD_ASSERT(a_status_empty, (m_tvalid && m_tuser == drld_pkg::KIND_STATUS) |-> (m_tdata[38:0] == '0), "status result carries run or sample")
	`DRLD_ASSERT(a_data_err, (m_tvalid && m_tuser != drld_pkg::KIND_STATUS) |-> (m_tdata[62:61] == drld_pkg::ERR_NONE || m_tdata[62:61] == drld_pkg::ERR_TRUNC), "data result with overflow or size error")
	`DRLD_NEVER(a_kind_range, m_tvalid && m_tuser == 2'd3, "undefined result kind")

endmodule

`default_nettype wire
